// ===== rtl/msic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msic_pkg: shared types and constants
// Request codes, halt causes, opcodes, functs, ALU operations and controller interface.
// ----------------------------------------------------------------------------
package msic_pkg;

	localparam int MemWords = 16384;
	localparam int MemAw = $clog2(MemWords);
	localparam logic [31:0] StartPcReset = 32'h0000_4000;

	localparam logic [2:0] REQ_MEM_WR = 3'd0;
	localparam logic [2:0] REQ_MEM_RD = 3'd1;
	localparam logic [2:0] REQ_EXEC   = 3'd2;
	localparam logic [2:0] REQ_REG_WR = 3'd3;
	localparam logic [2:0] REQ_REG_RD = 3'd4;

	localparam logic [2:0] HC_NONE   = 3'd0;
	localparam logic [2:0] HC_FETCH  = 3'd1;
	localparam logic [2:0] HC_OPCODE = 3'd2;
	localparam logic [2:0] HC_FUNCT  = 3'd3;
	localparam logic [2:0] HC_DATA   = 3'd4;

	localparam logic [5:0] OP_RTYPE = 6'd0;
	localparam logic [5:0] OP_J     = 6'd2;
	localparam logic [5:0] OP_BEQ   = 6'd4;
	localparam logic [5:0] OP_ADDI  = 6'd8;
	localparam logic [5:0] OP_SLTI  = 6'd10;
	localparam logic [5:0] OP_SLTIU = 6'd11;
	localparam logic [5:0] OP_LUI   = 6'd15;
	localparam logic [5:0] OP_LW    = 6'd35;
	localparam logic [5:0] OP_SW    = 6'd43;

	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_SLT  = 6'h2a;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	localparam logic [2:0] ALU_ADD  = 3'd0;
	localparam logic [2:0] ALU_SUB  = 3'd1;
	localparam logic [2:0] ALU_SLT  = 3'd2;
	localparam logic [2:0] ALU_SLTU = 3'd3;
	localparam logic [2:0] ALU_AND  = 3'd4;
	localparam logic [2:0] ALU_OR   = 3'd5;
	localparam logic [2:0] ALU_LUI  = 3'd6;

	typedef struct packed {
		logic       capture;
		logic       mem_rd;
		logic       fetch;
		logic       regs_rd;
		logic       exec;
		logic       commit;
		logic       out_load;
	} msic_cmd_t;

	typedef struct packed {
		logic       halted;
		logic       out_full;
		logic [2:0] req_type;
	} msic_sts_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [13:0] word_index;
		logic [4:0]  reg_index;
		logic [31:0] write_data;
	} msic_req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] pc;
		logic [31:0] instruction;
		logic [31:0] alu_result;
		logic        zero_flag;
		logic        halted;
		logic [2:0]  halt_cause;
	} msic_rsp_t;

	function automatic logic [31:0] alu_run(input logic [31:0] a, input logic [31:0] b,
			input logic [2:0] op);
		logic [31:0] r;
		unique case (op)
			ALU_ADD:  r = a + b;
			ALU_SUB:  r = a - b;
			ALU_SLT:  r = {31'd0, $signed(a) < $signed(b)};
			ALU_SLTU: r = {31'd0, a < b};
			ALU_AND:  r = a & b;
			ALU_OR:   r = a | b;
			default:  r = {b[15:0], 16'd0};
		endcase
		return r;
	endfunction

	function automatic logic addr_ok(input logic [31:0] addr);
		return (addr[1:0] == 2'b00) && ({2'b00, addr[31:2]} < 32'(MemWords));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/msic_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msic_if: valid/ready channels
// Request, response and start-address channels.
// ----------------------------------------------------------------------------
interface msic_req_if import msic_pkg::*; ();
	logic      valid;
	logic      ready;
	msic_req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface msic_rsp_if import msic_pkg::*; ();
	logic      valid;
	logic      ready;
	msic_rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface msic_cfg_if ();
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/msic_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msic_ctrl: request sequencer
// Steps each request through fetch and commit, with register read and execute for a running execute request.
// ----------------------------------------------------------------------------
module msic_ctrl import msic_pkg::*; (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	output logic      in_ready,
	input  msic_sts_t sts,
	output msic_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_REGS  = 3'd2;
	localparam logic [2:0] ST_EXEC  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				cmd.capture = 1'b1;
				state_d = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				cmd.mem_rd = 1'b1;
				state_d = (sts.req_type == REQ_EXEC && !sts.halted) ? ST_REGS : ST_DONE;
			end
			ST_REGS: begin
				cmd.regs_rd = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.commit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: if (!sts.out_full) begin
				cmd.out_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_FETCH) else $error("capture did not start fetch");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_full) else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> cmd.commit) else $error("execute not followed by commit");

endmodule

`default_nettype wire

// ===== rtl/msic_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msic_dp: core datapath
// Word memory, register file, PC, ALU, halt state and result register.
// ----------------------------------------------------------------------------
module msic_dp import msic_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  msic_cmd_t   cmd,
	output msic_sts_t   sts,
	input  msic_req_t   req,
	input  wire         cfg_we,
	input  wire  [31:0] cfg_data,
	output logic        out_valid,
	input  wire         out_ready,
	output msic_rsp_t   out_data
);

	logic [31:0] mem [MemWords];
	logic [31:0] regs_q [32];
	msic_req_t   req_q;
	logic [31:0] pc_q, mem_rd_q, ins_q, a_q, rt_val_q, rdata;
	logic        halt_q, fetch_ok_q;
	logic [2:0]  cause_q;
	logic        out_full_q;
	msic_rsp_t   rsp_q;

	logic [5:0]  op;
	logic [4:0]  rt, rd;
	logic [31:0] imm;
	logic        known_op, known_fn, use_imm;
	logic [2:0]  aluop;
	logic [MemAw-1:0] mem_addr;
	logic        idx_ok;
	logic [31:0] alu_y, res_s2, nxt;
	logic        go, bad_data, is_mem, ran, alu_ran;
	logic [31:0] rdata_s3, ins_s3, alu_s3;
	logic        zero_s3;

	assign op  = ins_q[31:26];
	assign rt  = ins_q[20:16];
	assign rd  = ins_q[15:11];
	assign imm = {{16{ins_q[15]}}, ins_q[15:0]};
	assign idx_ok = {18'd0, req_q.word_index} < 32'(MemWords);

	always_comb begin
		known_op = 1'b1;
		known_fn = 1'b1;
		use_imm = 1'b1;
		aluop = ALU_ADD;
		unique case (op)
			OP_RTYPE: begin
				use_imm = 1'b0;
				unique case (ins_q[5:0])
					FN_ADD:  aluop = ALU_ADD;
					FN_SUB:  aluop = ALU_SUB;
					FN_AND:  aluop = ALU_AND;
					FN_OR:   aluop = ALU_OR;
					FN_SLT:  aluop = ALU_SLT;
					FN_SLTU: aluop = ALU_SLTU;
					default: known_fn = 1'b0;
				endcase
			end
			OP_J:     use_imm = 1'b0;
			OP_BEQ: begin
				use_imm = 1'b0;
				aluop = ALU_SUB;
			end
			OP_ADDI, OP_LW, OP_SW: aluop = ALU_ADD;
			OP_SLTI:  aluop = ALU_SLT;
			OP_SLTIU: aluop = ALU_SLTU;
			OP_LUI:   aluop = ALU_LUI;
			default:  known_op = 1'b0;
		endcase
	end

	assign alu_y = alu_run(a_q, use_imm ? imm : rt_val_q, aluop);
	assign is_mem = (op == OP_LW) || (op == OP_SW);
	assign bad_data = is_mem && !addr_ok(res_s2);
	assign go = req_q.req_type == REQ_EXEC && !halt_q;
	assign ran = go && fetch_ok_q;
	assign alu_ran = ran && known_op && known_fn;

	always_comb begin
		if (cmd.fetch && req_q.req_type == REQ_EXEC) mem_addr = pc_q[MemAw+1:2];
		else if (cmd.exec) mem_addr = alu_y[MemAw+1:2];
		else mem_addr = req_q.word_index[MemAw-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
		if (cmd.mem_rd || cmd.exec) mem_rd_q <= mem[mem_addr];
		if (cmd.fetch) fetch_ok_q <= addr_ok(pc_q);
		if (cmd.regs_rd) begin
			ins_q <= mem_rd_q;
			a_q <= regs_q[mem_rd_q[25:21]];
			rt_val_q <= regs_q[mem_rd_q[20:16]];
		end
		if (cmd.exec) res_s2 <= alu_y;
		if (cmd.commit && req_q.req_type == REQ_MEM_WR && idx_ok)
			mem[req_q.word_index[MemAw-1:0]] <= req_q.write_data;
		if (cmd.commit && alu_ran && op == OP_SW && !bad_data)
			mem[res_s2[MemAw+1:2]] <= rt_val_q;
	end

	always_comb begin
		nxt = pc_q + 32'd4;
		if (op == OP_BEQ && res_s2 == 32'd0) nxt = nxt + {imm[29:0], 2'b00};
		if (op == OP_J) nxt = {nxt[31:28], ins_q[25:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= StartPcReset;
			halt_q <= 1'b0;
			cause_q <= HC_NONE;
			for (int i = 0; i < 32; i++) regs_q[i] <= '0;
		end else begin
			if (cfg_we) pc_q <= cfg_data;
			if (cmd.commit) begin
				unique case (req_q.req_type)
					REQ_REG_WR: if (req_q.reg_index != 5'd0) begin
						regs_q[req_q.reg_index] <= req_q.write_data;
					end
					REQ_EXEC: if (go) begin
						if (!fetch_ok_q) begin
							halt_q <= 1'b1;
							cause_q <= HC_FETCH;
						end else if (!known_op) begin
							halt_q <= 1'b1;
							cause_q <= HC_OPCODE;
						end else if (!known_fn) begin
							halt_q <= 1'b1;
							cause_q <= HC_FUNCT;
						end else if (bad_data) begin
							halt_q <= 1'b1;
							cause_q <= HC_DATA;
						end else begin
							pc_q <= nxt;
							if (op == OP_LW) begin
								if (rt != 5'd0) regs_q[rt] <= mem_rd_q;
							end else if (op == OP_RTYPE) begin
								if (rd != 5'd0) regs_q[rd] <= res_s2;
							end else if (op != OP_SW && op != OP_J && op != OP_BEQ) begin
								if (rt != 5'd0) regs_q[rt] <= res_s2;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (req_q.req_type)
			REQ_MEM_RD: rdata = idx_ok ? mem_rd_q : 32'd0;
			REQ_REG_RD: rdata = regs_q[req_q.reg_index];
			default:    rdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rdata_s3 <= rdata;
			ins_s3 <= ran ? ins_q : 32'd0;
			alu_s3 <= alu_ran ? res_s2 : 32'd0;
			zero_s3 <= alu_ran && res_s2 == 32'd0;
		end
		if (cmd.out_load) begin
			rsp_q.read_data <= rdata_s3;
			rsp_q.pc <= pc_q;
			rsp_q.instruction <= ins_s3;
			rsp_q.alu_result <= alu_s3;
			rsp_q.zero_flag <= zero_s3;
			rsp_q.halted <= halt_q;
			rsp_q.halt_cause <= cause_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_full_q <= 1'b0;
		else if (cmd.out_load) out_full_q <= 1'b1;
		else if (out_ready) out_full_q <= 1'b0;
	end

	assign out_valid = out_full_q;
	assign out_data = rsp_q;

	assign sts.halted = halt_q;
	assign sts.out_full = out_full_q && !out_ready;
	assign sts.req_type = req_q.req_type;

	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(halt_q) |-> 1'b0) else $error("halt cleared without reset");
	assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> cause_q != HC_NONE) else $error("halted without cause");
	assert property (@(posedge clk) disable iff (!arst_n)
		regs_q[0] == 32'd0) else $error("register zero written");

endmodule

`default_nettype wire

// ===== rtl/mips_subset_instruction_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_instruction_core: MIPS subset processor core
// Serves memory, register and execute requests one at a time.
// ----------------------------------------------------------------------------
// req carries one request transaction (req_type, word_index, reg_index,
// write_data); rsp returns one result transaction per request; cfg writes
// start_pc straight into the PC. Write cfg only while idle.
// An execute request steps through memory fetch, register read, execute,
// commit and result load; rsp is valid once the result is loaded, and the
// next request is taken only after that, so execute requests never overlap.
// Other requests, and execute requests while halted, skip register read and
// execute, and are likewise served one at a time.
// The single port of the word memory sets this sequence.
// The result register holds while rsp is stalled; the sequencer waits in
// its last step and takes no new request until the result is free.
// Reset clears the register file, halt state and PC (to start_pc reset);
// the word memory is undefined until written.
// ----------------------------------------------------------------------------
module mips_subset_instruction_core import msic_pkg::*; (
	input wire clk,
	input wire arst_n,
	msic_req_if.sink   req,
	msic_rsp_if.source rsp,
	msic_cfg_if.sink   cfg
);

	msic_cmd_t cmd;
	msic_sts_t sts;

	assign cfg.ready = 1'b1;

	msic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.sts(sts), .cmd(cmd)
	);

	msic_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req(req.data),
		.cfg_we(cfg.valid), .cfg_data(cfg.data),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
	);

endmodule

`default_nettype wire
